// File: rtl/spdcrc_pkg.sv
// spdcrc_pkg: shared constants, header type and crc-16 step for the packet deframer
// no dependencies; used by spdcrc_window and serial_packet_deframer_crc16_core
`timescale 1ns / 1ps
`default_nettype none

package spdcrc_pkg;

	localparam logic [7:0]  START_MARK  = 8'hFE;
	localparam logic [7:0]  END_MARK    = 8'hEF;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] ID_PING     = 16'h0001;
	localparam logic [15:0] ID_PING_RPL = 16'h0002;
	localparam logic [15:0] ID_ACK_MSG  = 16'h0006;
	localparam int unsigned HDR_LEN     = 8;
	localparam logic [8:0]  LIMIT_RESET = 9'd263;

	// header fields found in the hunting window
	typedef struct packed {
		logic        hit;
		logic [7:0]  length;
		logic [7:0]  flags;
		logic [15:0] id;
		logic [15:0] crc;
	} header_t;

	// status reported when a packet closes
	typedef struct packed {
		logic        crc_ok;
		logic [15:0] data_id;
		logic [7:0]  payload_size;
		logic        ack_request;
		logic        ping_request;
	} status_t;

	// one byte of crc-16 ccitt-false (poly 0x1021, msb first)
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] x;
		x = {8'h00, crc[15:8] ^ b};
		x = x ^ (x >> 4);
		return {crc[7:0], 8'h00} ^ (x << 12) ^ (x << 5) ^ x;
	endfunction

	// verdict and user fields for a closing packet
	function automatic status_t close_status(input logic [15:0] crc_calc,
			input logic [15:0] crc_exp, input logic [15:0] id,
			input logic [7:0] len, input logic [7:0] flags);
		status_t     st;
		logic        ok;
		logic [15:0] uid;
		logic [7:0]  usize;
		ok    = (crc_calc == crc_exp);
		uid   = ok ? id : 16'h0000;
		usize = ok ? len : 8'h00;
		st.crc_ok       = ok;
		st.ack_request  = ok && (uid != 16'h0000) && flags[0];
		st.ping_request = ok && (uid == ID_PING);
		// system messages are hidden from the user
		if ((uid == ID_PING) || (uid == ID_PING_RPL) || (uid == ID_ACK_MSG)) begin
			uid   = 16'h0000;
			usize = 8'h00;
		end
		st.data_id      = uid;
		st.payload_size = usize;
		return st;
	endfunction

endpackage

`default_nettype wire

// File: rtl/spdcrc_window.sv
// spdcrc_window: 8-byte hunting window and header match for the packet deframer
// depends on spdcrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module spdcrc_window (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                shift,
	input  wire logic [7:0]          rx_byte,
	input  wire logic [8:0]          frame_limit,
	output spdcrc_pkg::header_t      hdr
);

	localparam int unsigned DEPTH = spdcrc_pkg::HDR_LEN;

	logic [7:0] win_q [DEPTH];
	logic [9:0] frame_len;

	// header check on the window as it looks after this byte is shifted in
	always_comb begin
		frame_len  = {2'b00, win_q[2]} + 10'(DEPTH);
		hdr.length = win_q[2];
		hdr.flags  = win_q[3];
		hdr.id     = {win_q[4], win_q[5]};
		hdr.crc    = {win_q[6], win_q[7]};
		hdr.hit    = (win_q[1] == spdcrc_pkg::START_MARK) &&
		             (rx_byte == spdcrc_pkg::END_MARK) &&
		             (frame_len <= {1'b0, frame_limit});
	end

	// shift line, cleared once a header is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) win_q[i] <= 8'h00;
		end else if (shift) begin
			if (hdr.hit) begin
				for (int i = 0; i < DEPTH; i++) win_q[i] <= 8'h00;
			end else begin
				for (int i = 0; i < DEPTH - 1; i++) win_q[i] <= win_q[i + 1];
				win_q[DEPTH - 1] <= rx_byte;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/serial_packet_deframer_crc16_core.sv
// serial_packet_deframer_crc16_core: byte-serial packet deframer with crc-16 check
// depends on spdcrc_pkg and spdcrc_window
//
// usage:
//   input channel in_valid/in_ready carries one received byte (rx_byte) per transaction.
//   output channel out_valid/out_ready carries at most one result per input byte:
//   a payload byte (byte_present) and/or the close of a packet (packet_end with
//   crc_ok, data_id, payload_size, ack_request, ping_request).
//   hunting bytes and header bytes give no result, except the last header byte
//   of a zero-length packet, which closes it at once.
//   frame_limit is written with cfg_wr_en/cfg_wr_data while the block is idle.
//   output: a result is registered and appears on the output in the cycle after its byte is taken.
//   throughput: one byte per cycle; the only limit is the single output register,
//   which is refilled in the same cycle it is emptied.
//   reset: window cleared, hunting, frame_limit 263, output empty.
//   stall: while out_ready is low and a result is held, in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module serial_packet_deframer_crc16_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [8:0]  cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             byte_present,
	output logic [7:0]       payload_byte,
	output logic             packet_end,
	output logic             crc_ok,
	output logic [15:0]      data_id,
	output logic [7:0]       payload_size,
	output logic             ack_request,
	output logic             ping_request
);

	logic [8:0]  frame_limit_q;
	logic        in_payload_q;
	logic [7:0]  bytes_left_q;
	logic [15:0] running_crc_q;
	logic [15:0] expected_crc_q;
	logic [15:0] packet_id_q;
	logic [7:0]  packet_length_q;
	logic [7:0]  packet_flags_q;

	logic        out_valid_q;
	logic        byte_present_q;
	logic [7:0]  payload_byte_q;
	logic        packet_end_q;
	spdcrc_pkg::status_t status_q;

	logic                accept;
	spdcrc_pkg::header_t hdr;
	logic [15:0]         crc_next;
	logic [7:0]          left_next;
	logic                res_valid;
	logic                res_byte;
	logic                res_end;
	spdcrc_pkg::status_t res_status;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// hunting window
	spdcrc_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.shift       (accept && !in_payload_q),
		.rx_byte     (rx_byte),
		.frame_limit (frame_limit_q),
		.hdr         (hdr)
	);

	// per-byte result
	always_comb begin
		crc_next   = spdcrc_pkg::crc_step(running_crc_q, rx_byte);
		left_next  = bytes_left_q - 8'd1;
		res_byte   = in_payload_q;
		if (in_payload_q) begin
			res_end    = (left_next == 8'h00);
			res_status = spdcrc_pkg::close_status(crc_next, expected_crc_q, packet_id_q,
				packet_length_q, packet_flags_q);
		end else begin
			res_end    = hdr.hit && (hdr.length == 8'h00);
			res_status = spdcrc_pkg::close_status(spdcrc_pkg::CRC_INIT, hdr.crc, hdr.id,
				hdr.length, hdr.flags);
		end
		res_valid = res_byte || res_end;
		if (!res_end) res_status = '0;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q <= spdcrc_pkg::LIMIT_RESET;
		end else if (cfg_wr_en) begin
			frame_limit_q <= cfg_wr_data;
		end
	end

	// packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q    <= 1'b0;
			bytes_left_q    <= 8'h00;
			running_crc_q   <= spdcrc_pkg::CRC_INIT;
			expected_crc_q  <= 16'h0000;
			packet_id_q     <= 16'h0000;
			packet_length_q <= 8'h00;
			packet_flags_q  <= 8'h00;
		end else if (accept) begin
			if (in_payload_q) begin
				running_crc_q <= crc_next;
				bytes_left_q  <= left_next;
				if (left_next == 8'h00) in_payload_q <= 1'b0;
			end else if (hdr.hit) begin
				packet_length_q <= hdr.length;
				packet_flags_q  <= hdr.flags;
				packet_id_q     <= hdr.id;
				expected_crc_q  <= hdr.crc;
				running_crc_q   <= spdcrc_pkg::CRC_INIT;
				bytes_left_q    <= hdr.length;
				in_payload_q    <= (hdr.length != 8'h00);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= accept && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			byte_present_q <= res_byte;
			payload_byte_q <= res_byte ? rx_byte : 8'h00;
			packet_end_q   <= res_end;
			status_q       <= res_status;
		end
	end

	assign out_valid    = out_valid_q;
	assign byte_present = byte_present_q;
	assign payload_byte = payload_byte_q;
	assign packet_end   = packet_end_q;
	assign crc_ok       = status_q.crc_ok;
	assign data_id      = status_q.data_id;
	assign payload_size = status_q.payload_size;
	assign ack_request  = status_q.ack_request;
	assign ping_request = status_q.ping_request;

endmodule

`default_nettype wire

// File: bench/tb_deframer_checker.sv
`timescale 1ns / 1ps
// tb_deframer_checker: watches the byte, result and limit ports of the packet deframer,
// predicts every result from its own copy of the framing state and compares them
// depends on spdcrc_pkg for the marks, the crc seed and the system ids

module tb_deframer_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [8:0]  cfg_wr_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic        byte_present,
	input  wire logic [7:0]  payload_byte,
	input  wire logic        packet_end,
	input  wire logic        crc_ok,
	input  wire logic [15:0] data_id,
	input  wire logic [7:0]  payload_size,
	input  wire logic        ack_request,
	input  wire logic        ping_request,
	output int               fail_count,
	output int               pending_results
);

	import spdcrc_pkg::*;

	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam int          REPORT_MAX  = 10;

	typedef struct packed {
		logic        byte_present;
		logic [7:0]  payload_byte;
		logic        packet_end;
		logic        crc_ok;
		logic [15:0] data_id;
		logic [7:0]  payload_size;
		logic        ack_request;
		logic        ping_request;
	} deframe_result_t;

	// predicted framing state
	logic [8:0]      limit_q;
	logic [7:0]      hdr_win [0:HDR_LEN-1];
	logic            in_body;
	logic [7:0]      body_left;
	logic [15:0]     crc_run;
	logic [15:0]     crc_rx;
	logic [15:0]     pkt_id;
	logic [7:0]      pkt_len;
	logic [7:0]      pkt_flags;
	deframe_result_t expected_results [$];
	deframe_result_t seen_result;
	int              mismatches;

	// crc-16 ccitt-false over one byte, shifted a bit at a time
	function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++)
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		return c;
	endfunction

	function automatic string result_text(input deframe_result_t r);
		return $sformatf("byte %0d/%02h end %0d ok %0d id %04h size %0d ack %0d ping %0d",
			r.byte_present, r.payload_byte, r.packet_end, r.crc_ok, r.data_id,
			r.payload_size, r.ack_request, r.ping_request);
	endfunction

	// advance the framing state by one received byte, queue the result it causes
	task automatic predict_byte(input logic [7:0] b);
		deframe_result_t r;
		logic            closing;
		logic            good;
		r = '0;
		closing = 1'b0;
		if (in_body) begin
			r.byte_present = 1'b1;
			r.payload_byte = b;
			crc_run = crc_ccitt_byte(crc_run, b);
			body_left = body_left - 8'd1;
			closing = (body_left == 8'd0);
		end else begin
			for (int k = 0; k < HDR_LEN - 1; k++)
				hdr_win[k] = hdr_win[k + 1];
			hdr_win[HDR_LEN - 1] = b;
			if ((hdr_win[0] == START_MARK) && (hdr_win[HDR_LEN - 1] == END_MARK) &&
					(int'(hdr_win[1]) + HDR_LEN <= int'(limit_q))) begin
				pkt_len   = hdr_win[1];
				pkt_flags = hdr_win[2];
				pkt_id    = {hdr_win[3], hdr_win[4]};
				crc_rx    = {hdr_win[5], hdr_win[6]};
				for (int k = 0; k < HDR_LEN; k++)
					hdr_win[k] = 8'h00;
				crc_run   = CRC_INIT;
				body_left = pkt_len;
				in_body   = (pkt_len != 8'd0);
				closing   = (pkt_len == 8'd0);
			end
		end
		// packet close: verdict, then system ids hidden from the user
		if (closing) begin
			good = (crc_run == crc_rx);
			r.packet_end   = 1'b1;
			r.crc_ok       = good;
			r.data_id      = good ? pkt_id : 16'h0000;
			r.payload_size = good ? pkt_len : 8'h00;
			r.ack_request  = good && (pkt_id != 16'h0000) && pkt_flags[0];
			r.ping_request = good && (pkt_id == ID_PING);
			if ((r.data_id == ID_PING) || (r.data_id == ID_PING_RPL) ||
					(r.data_id == ID_ACK_MSG)) begin
				r.data_id      = 16'h0000;
				r.payload_size = 8'h00;
			end
			in_body   = 1'b0;
			body_left = 8'd0;
		end
		if (r.byte_present || r.packet_end)
			expected_results.push_back(r);
	endtask

	// compare a result transaction against the oldest prediction
	task automatic check_result(input deframe_result_t got);
		deframe_result_t want;
		logic            bad;
		if (expected_results.size() == 0) begin
			if (mismatches < REPORT_MAX)
				$display("%0t: result with nothing expected: %s", $time, result_text(got));
			mismatches++;
		end else begin
			want = expected_results.pop_front();
			bad = (got.byte_present !== want.byte_present) ||
				(got.payload_byte !== want.payload_byte) ||
				(got.packet_end !== want.packet_end) ||
				(got.crc_ok !== want.crc_ok) ||
				(got.data_id !== want.data_id) ||
				(got.payload_size !== want.payload_size) ||
				(got.ack_request !== want.ack_request) ||
				(got.ping_request !== want.ping_request);
			if (bad) begin
				if (mismatches < REPORT_MAX)
					$display("%0t: result mismatch\n  expected %s\n  actual   %s", $time,
						result_text(want), result_text(got));
				mismatches++;
			end
		end
	endtask

	// results are checked before the byte of the same edge is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   = LIMIT_RESET;
			for (int k = 0; k < HDR_LEN; k++)
				hdr_win[k] = 8'h00;
			in_body   = 1'b0;
			body_left = 8'd0;
			crc_run   = CRC_INIT;
			crc_rx    = 16'h0000;
			pkt_id    = 16'h0000;
			pkt_len   = 8'h00;
			pkt_flags = 8'h00;
			expected_results.delete();
			mismatches = 0;
			fail_count <= 0;
			pending_results <= 0;
		end else begin
			if (out_valid && out_ready) begin
				seen_result = {byte_present, payload_byte, packet_end, crc_ok, data_id,
					payload_size, ack_request, ping_request};
				check_result(seen_result);
			end
			if (in_valid && in_ready)
				predict_byte(rx_byte);
			if (cfg_wr_en)
				limit_q = cfg_wr_data;
			fail_count <= mismatches;
			pending_results <= expected_results.size();
		end
	end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: clock, reset, byte and limit stimulus and the verdict for the packet deframer
// depends on serial_packet_deframer_crc16_core, spdcrc_pkg and tb_deframer_checker

module tb_top;

	import spdcrc_pkg::*;

	localparam int          IDLE_LIMIT    = 5000;
	localparam int          PHASE_ITEMS   = 160;
	localparam int          DEAF_ITEMS    = 64;
	localparam int          SETTLE_CYCLES = 4;
	localparam int          NO_SPOIL      = -1;
	localparam logic [15:0] CRC_POLY      = 16'h1021;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [8:0]  cfg_wr_data = 9'd0;
	logic        in_valid    = 1'b0;
	logic [7:0]  rx_byte     = 8'h00;
	logic        out_ready   = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic        byte_present;
	logic [7:0]  payload_byte;
	logic        packet_end;
	logic        crc_ok;
	logic [15:0] data_id;
	logic [7:0]  payload_size;
	logic        ack_request;
	logic        ping_request;

	int          fail_count;
	int          pending_results;
	int          snd_idle    = 13;
	int          rcv_idle    = 85;
	int          idle_cycles = 0;
	logic [8:0]  limit_now   = LIMIT_RESET;
	logic [7:0]  body_buf [0:255];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	serial_packet_deframer_crc16_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.byte_present (byte_present),
		.payload_byte (payload_byte),
		.packet_end   (packet_end),
		.crc_ok       (crc_ok),
		.data_id      (data_id),
		.payload_size (payload_size),
		.ack_request  (ack_request),
		.ping_request (ping_request)
	);

	tb_deframer_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.byte_present    (byte_present),
		.payload_byte    (payload_byte),
		.packet_end      (packet_end),
		.crc_ok          (crc_ok),
		.data_id         (data_id),
		.payload_size    (payload_size),
		.ack_request     (ack_request),
		.ping_request    (ping_request),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	// receiver stalls
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rcv_idle);
	end

	// watchdog: too long without any transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("serial_packet_deframer_crc16_core regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// crc-16 ccitt-false over the first len bytes of body_buf
	function automatic logic [15:0] body_crc(input int len);
		logic [15:0] c;
		c = CRC_INIT;
		for (int n = 0; n < len; n++) begin
			c = c ^ {body_buf[n], 8'h00};
			for (int k = 0; k < 8; k++)
				c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	// one byte transaction, with a random gap in front of it
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// hold the sender until every predicted result has been taken
	task automatic wait_drained;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [8:0] value);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		limit_now = value;
	endtask

	// header (possibly cut short or with a mark spoilt) and optionally a random payload
	task automatic send_frame(input logic [7:0] len, input logic [7:0] flags,
			input logic [15:0] id, input logic crc_good, input int hdr_bytes,
			input logic with_body, input int spoil);
		logic [7:0]  hdr [0:HDR_LEN-1];
		logic [15:0] crc;
		logic [7:0]  flip;
		for (int n = 0; n < len; n++)
			body_buf[n] = 8'($urandom_range(0, 255));
		crc = 16'($urandom_range(0, 65535));
		if (crc_good)
			crc = body_crc(int'(len));
		hdr[0] = START_MARK;
		hdr[1] = len;
		hdr[2] = flags;
		hdr[3] = id[15:8];
		hdr[4] = id[7:0];
		hdr[5] = crc[15:8];
		hdr[6] = crc[7:0];
		hdr[7] = END_MARK;
		if (spoil >= 0) begin
			flip = 8'($urandom_range(1, 255));
			hdr[spoil] = hdr[spoil] ^ flip;
		end
		for (int n = 0; n < hdr_bytes; n++)
			send_byte(hdr[n]);
		if (with_body)
			for (int n = 0; n < len; n++)
				send_byte(body_buf[n]);
	endtask

	initial begin
		int          sent;
		int          target;
		int          room;
		int          pick;
		int          len;
		int          nbytes;
		logic        counted;
		logic [15:0] id;
		logic [8:0]  lim;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 6; ph++) begin
			// sender idles lightly first, then the receiver, then neither
			if (ph < 2) begin
				snd_idle = 13;
				rcv_idle = 85;
			end else if (ph < 4) begin
				snd_idle = 85;
				rcv_idle = 13;
			end else begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			case (ph)
				0: lim = 9'd263;
				1: lim = 9'd8;
				2: lim = 9'd0;
				3: lim = 9'd511;
				4: lim = 9'd50;
				default: lim = 9'd137;
			endcase
			write_limit(lim);

			// directed: ping with ack flag, all-ones id and flags, corrupted empty packet
			if (ph == 0) begin
				send_frame(8'd0, 8'h01, ID_PING, 1'b1, HDR_LEN, 1'b1, NO_SPOIL);
				send_frame(8'd2, 8'hFF, 16'hFFFF, 1'b1, HDR_LEN, 1'b1, NO_SPOIL);
				send_frame(8'd0, 8'h00, 16'h0000, 1'b0, HDR_LEN, 1'b1, NO_SPOIL);
			end

			// random traffic, mostly well-formed frames that fit the limit
			room = int'(limit_now) - int'(HDR_LEN);
			target = (room < 0) ? DEAF_ITEMS : PHASE_ITEMS;
			sent = 0;
			while (sent < target) begin
				case ($urandom_range(0, 11))
					0: id = 16'h0000;
					1: id = ID_PING;
					2: id = ID_PING_RPL;
					3: id = ID_ACK_MSG;
					default: id = 16'($urandom_range(0, 65535));
				endcase
				pick = $urandom_range(0, 99);
				counted = (room < 0);
				if ((pick < 70) && (room >= 0)) begin
					// well-formed frame, mostly short
					if ($urandom_range(0, 19) == 0)
						len = (room < 255) ? room : 255;
					else if ($urandom_range(0, 9) == 0)
						len = $urandom_range(0, (room < 255) ? room : 255);
					else
						len = $urandom_range(0, (room < 16) ? room : 16);
					send_frame(8'(len), 8'($urandom_range(0, 255)), id,
						$urandom_range(0, 4) != 0, HDR_LEN, 1'b1, NO_SPOIL);
					nbytes = HDR_LEN + len;
					counted = 1'b1;
				end else if (pick < 80) begin
					// header alone, too long for the limit where that is possible
					len = (room < 255) ? $urandom_range((room < 0) ? 0 : room + 1, 255) :
						$urandom_range(0, 255);
					send_frame(8'(len), 8'($urandom_range(0, 255)), id, 1'b1, HDR_LEN, 1'b0,
						NO_SPOIL);
					nbytes = HDR_LEN;
				end else if (pick < 90) begin
					// line noise, heavy in marks
					nbytes = $urandom_range(1, 12);
					for (int n = 0; n < nbytes; n++)
						case ($urandom_range(0, 3))
							0: send_byte(START_MARK);
							1: send_byte(END_MARK);
							default: send_byte(8'($urandom_range(0, 255)));
						endcase
				end else if ($urandom_range(0, 1) == 0) begin
					// spoilt start or end mark
					len = $urandom_range(0, 16);
					send_frame(8'(len), 8'($urandom_range(0, 255)), id, 1'b1, HDR_LEN, 1'b1,
						($urandom_range(0, 1) == 0) ? 0 : int'(HDR_LEN) - 1);
					nbytes = HDR_LEN + len;
				end else begin
					// header cut short
					nbytes = $urandom_range(1, HDR_LEN - 1);
					send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), id,
						1'b1, nbytes, 1'b0, NO_SPOIL);
				end
				if (counted)
					sent += nbytes;
				if ($urandom_range(0, 49) == 0)
					wait_drained();
			end
		end

		wait_drained();
		if ((fail_count == 0) && (pending_results == 0))
			$display("serial_packet_deframer_crc16_core regression: pass");
		else
			$display("serial_packet_deframer_crc16_core regression: fail");
		$finish;
	end

endmodule

// File: serial_packet_deframer_crc16_core.f
rtl/spdcrc_pkg.sv
rtl/spdcrc_window.sv
rtl/serial_packet_deframer_crc16_core.sv
bench/tb_deframer_checker.sv
bench/tb_top.sv
